// ----- rtl/expression_char_tokenizer_top_assert.svh -----
// assertion macros shared by the tokenizer rtl files
// expects clk and rst in scope of the including module
`ifndef EXPRESSION_CHAR_TOKENIZER_TOP_ASSERT_SVH
`define EXPRESSION_CHAR_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ECT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define ECT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ect_pkg.sv -----
// shared types, constants and character helpers for the expression tokenizer
// no dependencies
`default_nettype none

package ect_pkg;

  // line length limits
  localparam int MAX_LINE = 1024;
  localparam int POS_CAP_I = ((MAX_LINE - 1) > 1023) ? 1023 : (MAX_LINE - 1);
  localparam int LEN_CAP_I = (MAX_LINE > 2047) ? 2047 : MAX_LINE;
  localparam logic [9:0]  POS_CAP = 10'(POS_CAP_I);
  localparam logic [10:0] LEN_CAP = 11'(LEN_CAP_I);

  // keyword length in letters
  localparam logic [2:0] KW_LEN = 3'd6;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PERIOD = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;

  typedef enum logic [3:0] {
    K_END       = 4'd0,
    K_TYPE      = 4'd1,
    K_NAME      = 4'd2,
    K_ASSIGN    = 4'd3,
    K_DECIMAL   = 4'd4,
    K_INTEGER   = 4'd5,
    K_OPERATOR  = 4'd6,
    K_LPAREN    = 4'd7,
    K_RPAREN    = 4'd8,
    K_NEWLINE   = 4'd9,
    K_SEMICOLON = 4'd10,
    K_ERROR     = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_SUBTRACT = 3'd1,
    OP_MULTIPLY = 3'd2,
    OP_DIVIDE   = 3'd3,
    OP_ASSIGN   = 3'd4
  } op_t;

  // one output token
  typedef struct packed {
    kind_t       kind;
    op_t         op;
    logic [31:0] value;
    logic [10:0] frac;
    logic [9:0]  start;
    logic [10:0] len;
    logic        last;
  } tok_t;

  // up to two tokens produced by one character
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } tok_pair_t;

  function automatic tok_t make_tok(input kind_t k, input op_t o);
    tok_t t;
    t = '0;
    t.kind = k;
    t.op = o;
    return t;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // letters of the type keyword
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h64; // d
      3'd1:    r = 8'h6f; // o
      3'd2:    r = 8'h75; // u
      3'd3:    r = 8'h62; // b
      3'd4:    r = 8'h6c; // l
      3'd5:    r = 8'h65; // e
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // keyword match step, returns {alive, progress}
  function automatic logic [3:0] kw_step(input logic alive, input logic [2:0] prog,
                                         input logic [7:0] c);
    logic [3:0] r;
    r = {alive, prog};
    if (alive) begin
      if ((prog < KW_LEN) && (c == kw_char(prog))) begin
        r = {1'b1, 3'(prog + 3'd1)};
      end else begin
        r = {1'b0, prog};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ect_core.sv -----
// scanner state and per-character token logic
// depends on ect_pkg
`default_nettype none

module ect_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       ch,
  output ect_pkg::tok_pair_t    pair
);
  import ect_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NAME   = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_EQUAL  = 2'd3
  } mode_t;

  mode_t       mode, mode_next;
  logic [9:0]  position, position_next;
  logic [9:0]  token_start, token_start_next;
  logic [31:0] acc, acc_next;
  logic [10:0] frac, frac_next;
  logic        period, period_next;
  logic [2:0]  prog, prog_next;
  logic        alive, alive_next;

  logic        taken;
  logic        eq_v, f_v, s_v;
  tok_t        eq_tok, f_tok, s_tok;
  tok_t        name_tok, num_tok;
  logic [3:0]  kw_cont, kw_first;
  logic [3:0]  digit;

  assign digit    = 4'(ch - CH_ZERO);
  assign kw_cont  = kw_step(alive, prog, ch);
  assign kw_first = kw_step(1'b1, 3'd0, ch);

  // pending token forms
  always_comb begin
    name_tok = make_tok(K_NAME, OP_ADD);
    name_tok.start = token_start;
    name_tok.len = acc[10:0];
    num_tok = make_tok(period ? K_DECIMAL : K_INTEGER, OP_ADD);
    num_tok.value = acc;
    num_tok.frac = period ? frac : 11'd0;
  end

  // next state and tokens for the current character
  always_comb begin
    mode_next = mode;
    position_next = position;
    token_start_next = token_start;
    acc_next = acc;
    frac_next = frac;
    period_next = period;
    prog_next = prog;
    alive_next = alive;
    taken = 1'b0;
    eq_v = 1'b0;
    eq_tok = make_tok(K_OPERATOR, OP_ASSIGN);
    f_v = 1'b0;
    f_tok = make_tok(K_END, OP_ADD);
    s_v = 1'b0;
    s_tok = make_tok(K_END, OP_ADD);

    // continue the current token
    unique case (mode)
      MODE_NAME: begin
        if (is_letter(ch)) begin
          if (acc < {21'd0, LEN_CAP}) begin
            acc_next = acc + 32'd1;
          end
          {alive_next, prog_next} = kw_cont;
          taken = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(ch)) begin
          acc_next = (acc << 3) + (acc << 1) + {28'd0, digit};
          if (period && (frac < LEN_CAP)) begin
            frac_next = frac + 11'd1;
          end
          taken = 1'b1;
        end else if ((ch == CH_PERIOD) && !period) begin
          period_next = 1'b1;
          taken = 1'b1;
        end
      end
      MODE_EQUAL: begin
        if (ch == CH_EQUAL) begin
          eq_v = 1'b1;
          taken = 1'b1;
        end
      end
      MODE_IDLE: begin
      end
    endcase

    if (!taken) begin
      // flush the pending token
      unique case (mode)
        MODE_NAME: begin
          f_v = 1'b1;
          f_tok = (alive && (prog == KW_LEN)) ? make_tok(K_TYPE, OP_ADD) : name_tok;
        end
        MODE_NUMBER: begin
          f_v = 1'b1;
          f_tok = num_tok;
        end
        MODE_EQUAL: begin
          f_v = 1'b1;
          f_tok = make_tok(K_ASSIGN, OP_ASSIGN);
        end
        MODE_IDLE: begin
        end
      endcase
      mode_next = MODE_IDLE;
      acc_next = '0;
      frac_next = '0;
      period_next = 1'b0;
      prog_next = '0;
      alive_next = 1'b1;

      // start a new token from this character
      if (is_letter(ch)) begin
        mode_next = MODE_NAME;
        token_start_next = position;
        acc_next = 32'd1;
        {alive_next, prog_next} = kw_first;
      end else if (is_digit(ch) || (ch == CH_PERIOD)) begin
        mode_next = MODE_NUMBER;
        period_next = (ch == CH_PERIOD);
        acc_next = (ch == CH_PERIOD) ? 32'd0 : {28'd0, digit};
      end else begin
        s_v = 1'b1;
        case (ch)
          CH_NUL:    s_tok = make_tok(K_END, OP_ADD);
          CH_SPACE:  s_v = 1'b0;
          CH_EQUAL: begin
            s_v = 1'b0;
            mode_next = MODE_EQUAL;
          end
          CH_PLUS:   s_tok = make_tok(K_OPERATOR, OP_ADD);
          CH_MINUS:  s_tok = make_tok(K_OPERATOR, OP_SUBTRACT);
          CH_STAR:   s_tok = make_tok(K_OPERATOR, OP_MULTIPLY);
          CH_SLASH:  s_tok = make_tok(K_OPERATOR, OP_DIVIDE);
          CH_LPAREN: s_tok = make_tok(K_LPAREN, OP_ADD);
          CH_RPAREN: s_tok = make_tok(K_RPAREN, OP_ADD);
          CH_LF:     s_tok = make_tok(K_NEWLINE, OP_ADD);
          CH_SEMI:   s_tok = make_tok(K_SEMICOLON, OP_ADD);
          default:   s_tok = make_tok(K_ERROR, OP_ADD);
        endcase
      end
    end

    // end of line resets position, else position saturates
    if (ch == CH_NUL) begin
      position_next = '0;
      token_start_next = '0;
    end else if (position < POS_CAP) begin
      position_next = position + 10'd1;
    end
  end

  // order the tokens and mark the final one
  always_comb begin
    pair.v0 = 1'b0;
    pair.v1 = 1'b0;
    pair.t0 = s_tok;
    pair.t1 = s_tok;
    if (eq_v) begin
      pair.v0 = 1'b1;
      pair.t0 = eq_tok;
    end else if (f_v) begin
      pair.v0 = 1'b1;
      pair.t0 = f_tok;
      pair.v1 = s_v;
    end else begin
      pair.v0 = s_v;
    end
    if (pair.v1) begin
      pair.t1.last = 1'b1;
    end else begin
      pair.t0.last = 1'b1;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      position <= '0;
      token_start <= '0;
      acc <= '0;
      frac <= '0;
      period <= 1'b0;
      prog <= '0;
      alive <= 1'b1;
    end else if (step) begin
      mode <= mode_next;
      position <= position_next;
      token_start <= token_start_next;
      acc <= acc_next;
      frac <= frac_next;
      period <= period_next;
      prog <= prog_next;
      alive <= alive_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ect_fifo.sv -----
// four-entry token queue, takes up to two tokens per cycle, gives one unless the head is stalled
// depends on ect_pkg and expression_char_tokenizer_top_assert.svh
`default_nettype none

module ect_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ect_pkg::tok_pair_t push,
  output logic                  room,
  output logic                  head_valid,
  input  wire logic             head_stall,
  output ect_pkg::tok_t         head
);
  import ect_pkg::*;

  `include "expression_char_tokenizer_top_assert.svh"

  tok_t        mem [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count, count_next;
  logic [2:0]  n_push;
  logic        pop;

  // room for the two tokens a character can cause
  assign room       = (count <= 3'd2);
  assign head_valid = (count != 3'd0);
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && !head_stall;
  assign n_push     = {2'd0, push.v0} + {2'd0, push.v1};
  assign count_next = count + n_push - {2'd0, pop};

  // storage
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr] <= push.t0;
    end
    if (push.v1) begin
      mem[2'(wr_ptr + 2'd1)] <= push.t1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= 2'(wr_ptr + n_push[1:0]);
      rd_ptr <= 2'(rd_ptr + {1'b0, pop});
      count <= count_next;
    end
  end

  `ECT_IMPLY(a_push_room, push.v0, count <= 3'd2, "token pushed without room")
  `ECT_IMPLY(a_push_order, push.v1, push.v0, "second token pushed without first")
  `ECT_NEXT(a_count_max, 1'b1, count <= 3'd4, "token queue overflow")

endmodule

`default_nettype wire

// ----- rtl/expression_char_tokenizer_top.sv -----
// top level of the expression tokenizer: input register, scanner, token queue
// depends on ect_pkg, ect_core, ect_fifo and expression_char_tokenizer_top_assert.svh
`default_nettype none

// Streaming tokenizer: one line character per transaction on the ch channel,
// tokens out on the tok channel. A character is registered, then scanned
// once the queue has room, and its tokens enter a four-entry queue whose
// head drives the outputs. One character is taken per cycle as long as the
// queue has two free entries; a character that causes two tokens (a token
// ended by a character that makes one of its own) gives the output side two
// tokens to take, so the sustained rate is one character per cycle when the
// output side takes one token per cycle and tokens per character average at
// most one. Character 0 ends the line, emits the end token and returns the
// scanner to its reset state.
module expression_char_tokenizer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        ch_valid,
  output logic             ch_stall,
  input  wire logic [7:0]  ch,
  output logic             tok_valid,
  input  wire logic        tok_stall,
  output logic [3:0]       kind,
  output logic [2:0]       operator,
  output logic [31:0]      number_value,
  output logic [10:0]      fraction_digits,
  output logic [9:0]       name_start,
  output logic [10:0]      name_length,
  output logic             last
);
  import ect_pkg::*;

  `include "expression_char_tokenizer_top_assert.svh"

  logic        in_full;
  logic [7:0]  ch_q;
  logic        fire;
  logic        room;
  logic        accept;
  tok_pair_t   pair;
  tok_pair_t   push;
  tok_t        head;

  // input register handshake
  assign fire     = in_full && room;
  assign ch_stall = in_full && !room;
  assign accept   = ch_valid && !ch_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q <= ch;
    end
  end

  // scanner
  ect_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (fire),
    .ch   (ch_q),
    .pair (pair)
  );

  // only push when the character is actually scanned
  always_comb begin
    push = pair;
    push.v0 = pair.v0 && fire;
    push.v1 = pair.v1 && fire;
  end

  // output queue
  ect_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (tok_valid),
    .head_stall (tok_stall),
    .head       (head)
  );

  // token fields
  assign kind            = head.kind;
  assign operator        = head.op;
  assign number_value    = head.value;
  assign fraction_digits = head.frac;
  assign name_start      = head.start;
  assign name_length     = head.len;
  assign last            = head.last;

  `ECT_IMPLY(a_end_emits, fire && (ch_q == CH_NUL), pair.v0, "end of line gave no token")
  `ECT_IMPLY(a_no_stall_empty, !in_full, !ch_stall, "input stalled with empty register")

endmodule

`default_nettype wire

// ----- dv/tb_expression_char_tokenizer_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for expression_char_tokenizer_top: characters in, tokens out
// depends on ect_pkg and the tokenizer rtl; a local model predicts all untyped tokens
module tb_expression_char_tokenizer_top;
  import ect_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int SHORT_ITEMS = 540;
  localparam int LONG_RUN = 1030;
  localparam int FRAC_RUN = 12;
  localparam int MAX_REPORTS = 10;
  localparam int N_DIR = 27;
  localparam logic [7:0] CH_TOP = 8'hff;
  localparam logic [47:0] KW_WORD = "double";

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NAME,
    SCAN_NUMBER,
    SCAN_EQUAL
  } scan_t;

  // one directed character; typed rows carry their single token by hand
  typedef struct packed {
    logic [7:0] c;
    logic       typed;
    kind_t      k;
    op_t        o;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{CH_PLUS,   1'b1, K_OPERATOR,  OP_ADD},
    '{CH_MINUS,  1'b1, K_OPERATOR,  OP_SUBTRACT},
    '{CH_STAR,   1'b1, K_OPERATOR,  OP_MULTIPLY},
    '{CH_SLASH,  1'b1, K_OPERATOR,  OP_DIVIDE},
    '{CH_LPAREN, 1'b1, K_LPAREN,    OP_ADD},
    '{CH_RPAREN, 1'b1, K_RPAREN,    OP_ADD},
    '{CH_LF,     1'b1, K_NEWLINE,   OP_ADD},
    '{CH_SEMI,   1'b1, K_SEMICOLON, OP_ADD},
    '{CH_TOP,    1'b1, K_ERROR,     OP_ADD},
    '{"d",       1'b0, K_END,       OP_ADD},
    '{"o",       1'b0, K_END,       OP_ADD},
    '{"u",       1'b0, K_END,       OP_ADD},
    '{"b",       1'b0, K_END,       OP_ADD},
    '{"l",       1'b0, K_END,       OP_ADD},
    '{"e",       1'b0, K_END,       OP_ADD},
    '{CH_LPAREN, 1'b0, K_END,       OP_ADD},
    '{CH_EQUAL,  1'b0, K_END,       OP_ADD},
    '{CH_EQUAL,  1'b0, K_END,       OP_ADD},
    '{CH_EQUAL,  1'b0, K_END,       OP_ADD},
    '{"A",       1'b0, K_END,       OP_ADD},
    '{"z",       1'b0, K_END,       OP_ADD},
    '{"9",       1'b0, K_END,       OP_ADD},
    '{CH_PERIOD, 1'b0, K_END,       OP_ADD},
    '{CH_ZERO,   1'b0, K_END,       OP_ADD},
    '{CH_PERIOD, 1'b0, K_END,       OP_ADD},
    '{CH_SPACE,  1'b0, K_END,       OP_ADD},
    '{CH_NUL,    1'b1, K_END,       OP_ADD}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        ch_valid = 1'b0;
  logic        ch_stall;
  logic [7:0]  ch = 8'h00;
  logic        tok_valid;
  logic        tok_stall = 1'b0;
  logic [3:0]  kind;
  logic [2:0]  operator;
  logic [31:0] number_value;
  logic [10:0] fraction_digits;
  logic [9:0]  name_start;
  logic [10:0] name_length;
  logic        last;

  // scanner model state
  scan_t       mode;
  logic [9:0]  pos;
  logic [9:0]  tstart;
  logic [31:0] acc;
  logic [10:0] frac;
  logic        period;
  logic [2:0]  kw_prog;
  logic        kw_alive;

  tok_t        step_toks[$];
  tok_t        tok_expect_q[$];
  logic [7:0]  line_buf[$];

  // character on the bus and its hand-typed token, if any
  logic        cur_typed = 1'b0;
  kind_t       cur_kind = K_END;
  op_t         cur_op = OP_ADD;

  logic        gaps_on = 1'b1;
  int          fail_count = 0;
  int          quiet_cycles = 0;

  expression_char_tokenizer_top DUT (
    .clk(clk),
    .rst(rst),
    .ch_valid(ch_valid),
    .ch_stall(ch_stall),
    .ch(ch),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .kind(kind),
    .operator(operator),
    .number_value(number_value),
    .fraction_digits(fraction_digits),
    .name_start(name_start),
    .name_length(name_length),
    .last(last)
  );

  always #1 clk = ~clk;

  function automatic logic alpha_ch(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic void put_tok(input kind_t k, input op_t o, input logic [31:0] v,
                                  input logic [10:0] f, input logic [9:0] s,
                                  input logic [10:0] l);
    tok_t t;
    t.kind = k;
    t.op = o;
    t.value = v;
    t.frac = f;
    t.start = s;
    t.len = l;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void clear_scan();
    mode = SCAN_IDLE;
    acc = '0;
    frac = '0;
    period = 1'b0;
    kw_prog = '0;
    kw_alive = 1'b1;
  endfunction

  function automatic void scan_reset();
    clear_scan();
    pos = '0;
    tstart = '0;
  endfunction

  // follow the run against the letters of the type keyword
  function automatic void kw_match(input logic [7:0] c);
    if (kw_alive) begin
      if ((kw_prog < 3'd6) && (c == KW_WORD[8 * (5 - int'(kw_prog)) +: 8])) begin
        kw_prog = kw_prog + 3'd1;
      end else begin
        kw_alive = 1'b0;
      end
    end
  endfunction

  // advance the scanner by one character, tokens land in step_toks
  function automatic void scan_char(input logic [7:0] c);
    logic taken;
    taken = 1'b0;
    step_toks.delete();
    // extend the pending token if the character belongs to it
    case (mode)
      SCAN_NAME: begin
        if (alpha_ch(c)) begin
          if (acc < 32'(LEN_CAP)) acc = acc + 32'd1;
          kw_match(c);
          taken = 1'b1;
        end
      end
      SCAN_NUMBER: begin
        if (digit_ch(c)) begin
          acc = acc * 32'd10 + 32'(c - CH_ZERO);
          if (period && (frac < LEN_CAP)) frac = frac + 11'd1;
          taken = 1'b1;
        end else if ((c == CH_PERIOD) && !period) begin
          period = 1'b1;
          taken = 1'b1;
        end
      end
      SCAN_EQUAL: begin
        if (c == CH_EQUAL) begin
          put_tok(K_OPERATOR, OP_ASSIGN, '0, '0, '0, '0);
          taken = 1'b1;
        end
      end
      default: ;
    endcase
    if (!taken) begin
      // flush the pending token
      case (mode)
        SCAN_NAME: begin
          if (kw_alive && (kw_prog == 3'd6)) put_tok(K_TYPE, OP_ADD, '0, '0, '0, '0);
          else put_tok(K_NAME, OP_ADD, '0, '0, tstart, acc[10:0]);
        end
        SCAN_NUMBER: begin
          if (period) put_tok(K_DECIMAL, OP_ADD, acc, frac, '0, '0);
          else put_tok(K_INTEGER, OP_ADD, acc, '0, '0, '0);
        end
        SCAN_EQUAL: put_tok(K_ASSIGN, OP_ASSIGN, '0, '0, '0, '0);
        default: ;
      endcase
      clear_scan();
      // open a new token or emit a single-character one
      if (alpha_ch(c)) begin
        mode = SCAN_NAME;
        tstart = pos;
        acc = 32'd1;
        kw_match(c);
      end else if (digit_ch(c) || (c == CH_PERIOD)) begin
        mode = SCAN_NUMBER;
        period = (c == CH_PERIOD);
        acc = period ? 32'd0 : 32'(c - CH_ZERO);
      end else begin
        case (c)
          CH_NUL:    put_tok(K_END, OP_ADD, '0, '0, '0, '0);
          CH_SPACE:  ;
          CH_EQUAL:  mode = SCAN_EQUAL;
          CH_PLUS:   put_tok(K_OPERATOR, OP_ADD, '0, '0, '0, '0);
          CH_MINUS:  put_tok(K_OPERATOR, OP_SUBTRACT, '0, '0, '0, '0);
          CH_STAR:   put_tok(K_OPERATOR, OP_MULTIPLY, '0, '0, '0, '0);
          CH_SLASH:  put_tok(K_OPERATOR, OP_DIVIDE, '0, '0, '0, '0);
          CH_LPAREN: put_tok(K_LPAREN, OP_ADD, '0, '0, '0, '0);
          CH_RPAREN: put_tok(K_RPAREN, OP_ADD, '0, '0, '0, '0);
          CH_LF:     put_tok(K_NEWLINE, OP_ADD, '0, '0, '0, '0);
          CH_SEMI:   put_tok(K_SEMICOLON, OP_ADD, '0, '0, '0, '0);
          default:   put_tok(K_ERROR, OP_ADD, '0, '0, '0, '0);
        endcase
      end
    end
    // end of line returns to reset, otherwise the position saturates
    if (c == CH_NUL) begin
      scan_reset();
    end else if (pos < POS_CAP) begin
      pos = pos + 10'd1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(CH_UPPER_A + r) : 8'(CH_LOWER_A + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // mostly well-formed expression text with some noise, usually closed by nul
  function automatic void build_line(input logic long_line);
    int    pieces;
    int    pick;
    int    n;
    int    dot_at;
    string word;
    line_buf.delete();
    if (long_line) begin
      // name past the length limit, then a short fraction, position saturates
      for (int i = 0; i < LONG_RUN; i++) line_buf.push_back(rand_letter());
      line_buf.push_back(CH_SPACE);
      line_buf.push_back(CH_PERIOD);
      for (int i = 0; i < FRAC_RUN; i++) line_buf.push_back(rand_digit());
      line_buf.push_back(CH_PLUS);
      line_buf.push_back("q");
      line_buf.push_back(CH_NUL);
      return;
    end
    pieces = $urandom_range(1, 12);
    for (int p = 0; p < pieces; p++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // names, now and then the keyword or a near miss
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 3))
            0: word = "double";
            1: word = "doubl";
            2: word = "doubles";
            default: word = "Double";
          endcase
          for (int i = 0; i < word.len(); i++) line_buf.push_back(word[i]);
        end else begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) line_buf.push_back(rand_letter());
        end
      end else if (pick < 45) begin
        // numbers up to 14 digits, half with a period, some with a second one
        n = $urandom_range(1, 14);
        dot_at = $urandom_range(0, 2 * n);
        for (int i = 0; i <= n; i++) begin
          if (i == dot_at) line_buf.push_back(CH_PERIOD);
          if (i < n) line_buf.push_back(rand_digit());
        end
        if ($urandom_range(0, 9) == 0) begin
          line_buf.push_back(CH_PERIOD);
          line_buf.push_back(rand_digit());
        end
      end else if (pick < 62) begin
        case ($urandom_range(0, 3))
          0: line_buf.push_back(CH_PLUS);
          1: line_buf.push_back(CH_MINUS);
          2: line_buf.push_back(CH_STAR);
          default: line_buf.push_back(CH_SLASH);
        endcase
      end else if (pick < 70) begin
        line_buf.push_back(CH_EQUAL);
        if ($urandom_range(0, 1) == 1) line_buf.push_back(CH_EQUAL);
      end else if (pick < 78) begin
        line_buf.push_back(($urandom_range(0, 1) == 1) ? CH_LPAREN : CH_RPAREN);
      end else if (pick < 88) begin
        line_buf.push_back(CH_SPACE);
      end else if (pick < 93) begin
        line_buf.push_back(($urandom_range(0, 1) == 1) ? CH_LF : CH_SEMI);
      end else begin
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) line_buf.push_back(CH_NUL);
  endfunction

  // drive one character transaction, entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic typed, input kind_t k,
                           input op_t o);
    while (gaps_on && ($urandom_range(0, 99) < 9)) begin
      ch_valid <= 1'b0;
      ch <= 8'($urandom);
      @(negedge clk);
    end
    cur_typed = typed;
    cur_kind = k;
    cur_op = o;
    ch_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (ch_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    tok_stall <= gaps_on && ($urandom_range(0, 99) < 9);
  end

  // predict on accepted characters, check accepted tokens
  always @(posedge clk) begin
    tok_t got;
    tok_t want;
    if (!rst) begin
      if (ch_valid && !ch_stall) begin
        scan_char(ch);
        if (cur_typed) begin
          want = '0;
          want.kind = cur_kind;
          want.op = cur_op;
          want.last = 1'b1;
          tok_expect_q.push_back(want);
        end else begin
          foreach (step_toks[i]) tok_expect_q.push_back(step_toks[i]);
        end
      end
      if (tok_valid && !tok_stall) begin
        got.kind = kind_t'(kind);
        got.op = op_t'(operator);
        got.value = number_value;
        got.frac = fraction_digits;
        got.start = name_start;
        got.len = name_length;
        got.last = last;
        if (tok_expect_q.size() == 0) begin
          log_failure($sformatf("unexpected token: kind %0d op %0d value %0h", kind,
                                operator, number_value));
        end else begin
          want = tok_expect_q.pop_front();
          if ((got.kind !== want.kind) || (got.op !== want.op) ||
              (got.value !== want.value) || (got.frac !== want.frac) ||
              (got.start !== want.start) || (got.len !== want.len) ||
              (got.last !== want.last)) begin
            log_failure($sformatf({"token mismatch: want kind %0d op %0d value %0h ",
                                   "frac %0d start %0d len %0d last %0b; got kind %0d ",
                                   "op %0d value %0h frac %0d start %0d len %0d last %0b"},
                                  want.kind, want.op, want.value, want.frac, want.start,
                                  want.len, want.last, kind, operator, number_value,
                                  fraction_digits, name_start, name_length, last));
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (ch_valid && !ch_stall) || (tok_valid && !tok_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int rand_sent;
    scan_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      send_char(DIR_TAB[i].c, DIR_TAB[i].typed, DIR_TAB[i].k, DIR_TAB[i].o);
    end

    // hold the sender until every token has come out
    ch_valid <= 1'b0;
    @(negedge clk);
    while (tok_expect_q.size() != 0) @(negedge clk);

    // one very long line, then random short lines
    build_line(1'b1);
    foreach (line_buf[i]) send_char(line_buf[i], 1'b0, K_END, OP_ADD);
    rand_sent = 0;
    while (rand_sent < SHORT_ITEMS) begin
      // a stretch with no gaps and no stalls
      gaps_on <= !((rand_sent >= 150) && (rand_sent < 400));
      build_line(1'b0);
      foreach (line_buf[i]) begin
        send_char(line_buf[i], 1'b0, K_END, OP_ADD);
        rand_sent++;
      end
    end
    send_char(CH_NUL, 1'b0, K_END, OP_ADD);
    ch_valid <= 1'b0;

    // drain
    while (tok_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
